FILE: src/fch_pkg.sv
// Package: shared types, register indexes and reset constants of the follow controller.
package fch_pkg;

	localparam int VAL_W  = 16;
	localparam int PAR_W  = 15;
	localparam int AGE_W  = 6;
	localparam int CFG_IW = 3;

	localparam logic [AGE_W-1:0] AGE_MAX = 6'd63;

	// Input command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_GOAL = 1'b1;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IW-1:0] {
		REG_LINEAR_GAIN  = 3'd0,
		REG_ANGULAR_GAIN = 3'd1,
		REG_GOAL_DIST    = 3'd2,
		REG_BAND_HIGH    = 3'd3,
		REG_BAND_LOW     = 3'd4,
		REG_ANGLE_BAND   = 3'd5,
		REG_DIST_TOL     = 3'd6,
		REG_ANGLE_TOL    = 3'd7
	} reg_idx_t;

	// Register reset values, unsigned Q3.12
	localparam logic [PAR_W-1:0] RST_LINEAR_GAIN  = 15'd4096;
	localparam logic [PAR_W-1:0] RST_ANGULAR_GAIN = 15'd6144;
	localparam logic [PAR_W-1:0] RST_GOAL_DIST    = 15'd4096;
	localparam logic [PAR_W-1:0] RST_BAND_HIGH    = 15'd4915;
	localparam logic [PAR_W-1:0] RST_BAND_LOW     = 15'd3277;
	localparam logic [PAR_W-1:0] RST_ANGLE_BAND   = 15'd717;
	localparam logic [PAR_W-1:0] RST_DIST_TOL     = 15'd41;
	localparam logic [PAR_W-1:0] RST_ANGLE_TOL    = 15'd164;

	// Stored target after reset: 1.0 m straight ahead
	localparam logic [VAL_W-1:0] RST_DISTANCE = 16'd4096;
	localparam logic [VAL_W-1:0] RST_BEARING  = 16'd0;

	typedef struct packed {
		logic                    cmd;
		logic signed [VAL_W-1:0] target_distance;
		logic signed [VAL_W-1:0] target_bearing;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] linear_velocity;
		logic signed [VAL_W-1:0] angular_velocity;
		logic                    last;
	} out_t;

	typedef struct packed {
		logic [PAR_W-1:0] linear_gain;
		logic [PAR_W-1:0] angular_gain;
		logic [PAR_W-1:0] goal_distance;
		logic [PAR_W-1:0] band_high;
		logic [PAR_W-1:0] band_low;
		logic [PAR_W-1:0] angle_band;
		logic [PAR_W-1:0] distance_tolerance;
		logic [PAR_W-1:0] angle_tolerance;
	} cfg_t;

	// Result writes from the control law into the output queue
	typedef struct packed {
		logic push0;
		logic push1;
		out_t res0;
		out_t res1;
	} push_t;

endpackage

FILE: src/fch_cfg.sv
// Configuration register file of the follow controller.
module fch_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [fch_pkg::CFG_IW-1:0] wr_index,
	input  logic [fch_pkg::PAR_W-1:0]  wr_data,
	output fch_pkg::cfg_t              cfg
);
	import fch_pkg::*;

	cfg_t cfg_q;

	// Register writes, one beat per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.linear_gain        <= RST_LINEAR_GAIN;
			cfg_q.angular_gain       <= RST_ANGULAR_GAIN;
			cfg_q.goal_distance      <= RST_GOAL_DIST;
			cfg_q.band_high          <= RST_BAND_HIGH;
			cfg_q.band_low           <= RST_BAND_LOW;
			cfg_q.angle_band         <= RST_ANGLE_BAND;
			cfg_q.distance_tolerance <= RST_DIST_TOL;
			cfg_q.angle_tolerance    <= RST_ANGLE_TOL;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_LINEAR_GAIN:  cfg_q.linear_gain        <= wr_data;
				REG_ANGULAR_GAIN: cfg_q.angular_gain       <= wr_data;
				REG_GOAL_DIST:    cfg_q.goal_distance      <= wr_data;
				REG_BAND_HIGH:    cfg_q.band_high          <= wr_data;
				REG_BAND_LOW:     cfg_q.band_low           <= wr_data;
				REG_ANGLE_BAND:   cfg_q.angle_band         <= wr_data;
				REG_DIST_TOL:     cfg_q.distance_tolerance <= wr_data;
				REG_ANGLE_TOL:    cfg_q.angle_tolerance    <= wr_data;
				default:          cfg_q.angle_tolerance    <= cfg_q.angle_tolerance;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/fch_ctrl.sv
// Input register, follower state and the proportional control law.
module fch_ctrl #(
	parameter int TIMEOUT_TICKS = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fch_pkg::in_t   in_data,
	input  fch_pkg::cfg_t  cfg,
	input  logic           room,
	output fch_pkg::push_t push
);
	import fch_pkg::*;

	localparam logic [AGE_W-1:0] TIMEOUT = AGE_W'(TIMEOUT_TICKS);
	localparam int PL_W = VAL_W + 1 + PAR_W + 1;   // distance error times gain
	localparam int PA_W = VAL_W + PAR_W + 1;       // bearing times gain

	logic                    valid_s1;
	in_t                     item_s1;
	logic                    following_q;
	logic signed [VAL_W-1:0] dist_q;
	logic signed [VAL_W-1:0] bear_q;
	logic [AGE_W-1:0]        age_q;

	logic                    proc;
	logic                    take;
	logic [AGE_W-1:0]        age_n;
	logic signed [VAL_W:0]   err;
	logic signed [PL_W-1:0]  lin_p;
	logic signed [PA_W-1:0]  ang_p;
	logic signed [PL_W-13:0] lin_fl;
	logic signed [PA_W-12:0] ang_neg;
	logic [VAL_W:0]          err_abs;
	logic [VAL_W:0]          bear_abs;
	logic                    reached;
	logic                    outside;
	logic                    stale;
	logic                    fresh;
	out_t                    prop;
	out_t                    zero;

	function automatic logic signed [VAL_W-1:0] sat_lin(input logic signed [PL_W-13:0] x);
		if (x > $signed((PL_W-12)'(32767)))
			sat_lin = 16'sh7FFF;
		else if (x < -$signed((PL_W-12)'(32768)))
			sat_lin = 16'sh8000;
		else
			sat_lin = x[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_ang(input logic signed [PA_W-12:0] x);
		if (x > $signed((PA_W-11)'(32767)))
			sat_ang = 16'sh7FFF;
		else if (x < -$signed((PA_W-11)'(32768)))
			sat_ang = 16'sh8000;
		else
			sat_ang = x[VAL_W-1:0];
	endfunction

	// Handshake: the input register moves on when its item goes through
	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

	// Saturating goal age after this tick
	assign age_n = (age_q == AGE_MAX) ? age_q : age_q + 1'b1;
	assign stale = following_q && (age_n > TIMEOUT);
	assign fresh = age_n < TIMEOUT;

	// Proportional law; arithmetic shift gives the floor
	assign err     = {dist_q[VAL_W-1], dist_q} - $signed({2'b00, cfg.goal_distance});
	assign lin_p   = err * $signed({1'b0, cfg.linear_gain});
	assign ang_p   = bear_q * $signed({1'b0, cfg.angular_gain});
	assign lin_fl  = lin_p[PL_W-1:12];
	assign ang_neg = -$signed({ang_p[PA_W-1], ang_p[PA_W-1:12]});

	// Goal reached and hysteresis band tests
	assign err_abs  = err[VAL_W] ? (VAL_W+1)'(-err) : err;
	assign bear_abs = bear_q[VAL_W-1] ? (VAL_W+1)'(-{bear_q[VAL_W-1], bear_q})
	                                  : {1'b0, bear_q};
	assign reached  = (err_abs <= {2'b00, cfg.distance_tolerance})
	               && (bear_abs <= {2'b00, cfg.angle_tolerance});
	assign outside  = (dist_q > $signed({1'b0, cfg.band_high}))
	               || (dist_q < $signed({1'b0, cfg.band_low}))
	               || (bear_q > $signed({1'b0, cfg.angle_band}))
	               || ($signed({bear_q[VAL_W-1], bear_q}) < -$signed({2'b00, cfg.angle_band}));

	always_comb begin
		prop.linear_velocity  = sat_lin(lin_fl);
		prop.angular_velocity = sat_ang(ang_neg);
		prop.last             = !reached;
		zero.linear_velocity  = '0;
		zero.angular_velocity = '0;
		zero.last             = 1'b1;
	end

	// Result writes for this item
	always_comb begin
		push.push0 = 1'b0;
		push.push1 = 1'b0;
		push.res0  = zero;
		push.res1  = zero;
		if (proc && item_s1.cmd == CMD_TICK && following_q) begin
			push.push0 = 1'b1;
			if (!stale) begin
				push.res0  = prop;
				push.push1 = reached;
			end
		end
	end

	// Follower state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			following_q <= 1'b0;
			dist_q      <= RST_DISTANCE;
			bear_q      <= RST_BEARING;
			age_q       <= '0;
		end else if (proc) begin
			if (item_s1.cmd == CMD_GOAL) begin
				dist_q <= item_s1.target_distance;
				bear_q <= item_s1.target_bearing;
				age_q  <= '0;
			end else begin
				age_q <= age_n;
				if (following_q) begin
					if (stale || reached) begin
						following_q <= 1'b0;
					end
				end else if (outside && fresh) begin
					following_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/fch_fifo.sv
// Four-entry result queue, up to two writes and one read per cycle.
module fch_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  fch_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output fch_pkg::out_t  out_data
);
	import fch_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	out_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	// Space for the two beats a tick may produce
	assign room      = cnt_q <= (PTR_W+1)'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wr_q + 1'b1] <= push.res1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.push0) + PTR_W'(push.push1);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + (PTR_W+1)'(push.push0) + (PTR_W+1)'(push.push1)
			       - (PTR_W+1)'(pop);
		end
	end

endmodule

FILE: src/follow_controller_with_hysteresis.sv
// Top level of the two-mode target follower with hysteresis.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | in_valid / in_stall     | in_data: cmd, target_distance, bearing
//  out     | out_valid / out_stall   | out_data: linear, angular velocity, last
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// An accepted item sits in the input register, where the control law
// runs; its beats show at the output the cycle after. One item per cycle is
// taken while the four-entry result queue has room for two beats.
// Reset puts the block in waiting with a 1.0 m goal straight ahead, age zero.
// out_stall only fills the queue; in_stall rises once the queue is that full.
module follow_controller_with_hysteresis #(
	parameter int TIMEOUT_TICKS = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  fch_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output fch_pkg::out_t              out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fch_pkg::CFG_IW-1:0] cfg_index,
	input  logic [fch_pkg::PAR_W-1:0]  cfg_data
);
	import fch_pkg::*;

	cfg_t  cfg;
	push_t push;
	logic  room;

	assign cfg_ready = 1'b1;

	fch_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fch_ctrl #(
		.TIMEOUT_TICKS (TIMEOUT_TICKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg),
		.room     (room),
		.push     (push)
	);

	fch_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
